>>> hdl/wvm_pkg.sv
// wvm_pkg: shared widths, codes and types for the wavetable voice mixer
// no dependencies
`timescale 1ns / 1ps

package wvm_pkg;

   localparam int OP_W       = 2;
   localparam int ADDR_W     = 15;
   localparam int DATA_W     = 8;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int GAIN_W     = 8;
   localparam int NIB_W      = 4;
   localparam int SUM_W      = 11;   // eight voices of +-120 fit in 11 signed bits
   localparam int MAG_W      = 10;
   localparam int LOW_REGS   = 64;
   localparam int VAL_W      = 15;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd48;
   localparam logic [VAL_W-1:0]  VAL_MAX    = 15'd32767;
   localparam logic [DATA_W-1:0] END_BYTE   = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_REG_WRITE = 2'd0,
      OP_ROM_LOAD  = 2'd1,
      OP_TICK      = 2'd2,
      OP_RESERVED  = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 1'b1;

   // scaler handshake between sequencer and output scaling
   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] sum;
      logic [GAIN_W-1:0]       gain;
   } scale_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] sample;
   } scale_rsp_type;

endpackage

>>> hdl/wvm_req_if.sv
// wvm_req_if: request channel carrying operation, address and data
// depends on wvm_pkg
`timescale 1ns / 1ps

interface wvm_req_if import wvm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] data;

   modport source (output valid, operation, address, data, input ready);
   modport sink   (input valid, operation, address, data, output ready);
endinterface

>>> hdl/wvm_rsp_if.sv
// wvm_rsp_if: response channel carrying one mixed sample
// depends on wvm_pkg
`timescale 1ns / 1ps

interface wvm_rsp_if import wvm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

>>> hdl/wvm_phase_mem.sv
// wvm_phase_mem: per-voice phase accumulator memory with a registered read
// entries read as zero until first written; depends on wvm_pkg
`timescale 1ns / 1ps

module wvm_phase_mem import wvm_pkg::*; #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 32,
   parameter int AW    = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] written_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         rd_written_ff <= written_ff[rd_addr];
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : '0;

endmodule

>>> hdl/wvm_wave_mem.sv
// wvm_wave_mem: byte-wide wave sample memory, one write and one read port
// depends on wvm_pkg
`timescale 1ns / 1ps

module wvm_wave_mem import wvm_pkg::*; #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/wvm_mix_scaler.sv
// wvm_mix_scaler: three-stage gain, divide by voice count and clamp
// depends on wvm_pkg
`timescale 1ns / 1ps

module wvm_mix_scaler import wvm_pkg::*; #(
   parameter int MIX_VOICES = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  scale_req_type req,
   output scale_rsp_type rsp
);

   localparam int RECIP_SHIFT = 24;
   localparam int LIMIT       = 32768 * MIX_VOICES;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + MIX_VOICES - 1) / MIX_VOICES;
   localparam int MG_W        = MAG_W + GAIN_W;
   localparam int PROD_W      = MG_W + 4;
   localparam int X_W         = 18;
   localparam int R_W         = RECIP_SHIFT + 1;

   logic                       v1_ff, v2_ff, v3_ff;
   logic                       neg1_ff, neg2_ff;
   logic [PROD_W-1:0]          prod1_ff;
   logic                       over2_ff;
   logic [X_W+R_W-1:0]         mul2_ff;
   logic signed [SAMPLE_W-1:0] sample3_ff;
   logic [MAG_W-1:0]           mag;
   logic [SUM_W-1:0]           abs_sum;
   logic [VAL_W-1:0]           val;

   always_comb begin
      abs_sum = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
      mag     = abs_sum[MAG_W-1:0];
      val     = over2_ff ? VAL_MAX : mul2_ff[RECIP_SHIFT +: VAL_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= req.start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg1_ff    <= req.sum[SUM_W-1];
      prod1_ff   <= {MG_W'(mag) * MG_W'(req.gain), 4'b0000};
      neg2_ff    <= neg1_ff;
      over2_ff   <= (prod1_ff >= PROD_W'(LIMIT));
      mul2_ff    <= prod1_ff[X_W-1:0] * R_W'(RECIP);
      sample3_ff <= neg2_ff ? -$signed({1'b0, val}) : $signed({1'b0, val});
   end

   assign rsp.done   = v3_ff;
   assign rsp.sample = sample3_ff;

endmodule

>>> hdl/wavetable_voice_mixer_8ch.sv
// wavetable_voice_mixer_8ch: top level, register bank, tick sequencer, output register
// depends on wvm_pkg, wvm_req_if, wvm_rsp_if, wvm_phase_mem, wvm_wave_mem, wvm_mix_scaler
`timescale 1ns / 1ps

// usage
//   req_if carries one operation per transfer: a register write, a wave byte
//   load or a sample tick. rsp_if carries one signed sample for every tick and
//   nothing for the other operations. csr_* writes gain (index 0) and enable
//   (index 1); the user must do it only while idle; the block does not check.
// operation flow
//   register writes and wave loads can follow back to back.
//   a tick walks the voices through the phase memory and wave memory, one voice
//   issued per cycle with a two-deep read pipeline, then a three-stage scaler;
//   the next request is taken once the sample has moved to the output register.
//   a tick with enable low answers zero without walking the voices.
// reset
//   synchronous, active high: gain 48, enable 1, all voice registers, phases
//   and play flags cleared. the wave memory is not cleared and must be loaded.
// stall
//   the sample sits in an output register; a new request is taken while it
//   waits, and a finished tick holds until the output register frees up.

module wavetable_voice_mixer_8ch import wvm_pkg::*; #(
   parameter int MIX_VOICES = 8,
   parameter int ROM_BYTES  = 32768,
   parameter int PHASE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   wvm_req_if.sink               req_if,
   wvm_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int VIW  = (MIX_VOICES > 1) ? $clog2(MIX_VOICES) : 1;
   localparam int CW   = $clog2(MIX_VOICES + 1);
   localparam int RAW  = $clog2(ROM_BYTES);
   localparam int SW   = 18;   // wave address sum before wrap
   localparam int IDXW = PHASE_BITS - 16;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_SCALE, ST_DONE} state_type;

   // configuration and voice registers
   logic [GAIN_W-1:0] gain_ff;
   logic              enable_ff;
   logic [NIB_W-1:0]  low_regs_ff [LOW_REGS];
   logic [NIB_W-1:0]  hb5_ff      [MIX_VOICES];   // high bank, offset 5 of each voice
   logic [NIB_W-1:0]  hbl_ff      [MIX_VOICES];   // high bank as latched at recompute
   logic [MIX_VOICES-1:0] playing_ff, playing_in;

   // per-voice decode of the register bank
   logic [11:0]        freq_w [MIX_VOICES];
   logic [NIB_W-1:0]   vol_w  [MIX_VOICES];
   logic [ADDR_W-1:0]  base_w [MIX_VOICES];
   logic [MIX_VOICES-1:0] shot_w;
   logic [MIX_VOICES-1:0] new_shot_w;

   // sequencer
   state_type                 state_ff;
   logic [CW-1:0]             cnt_ff;
   logic                      b_valid_ff;
   logic [VIW-1:0]            b_voice_ff;
   logic                      c_valid_ff;
   logic [VIW-1:0]            c_voice_ff;
   logic                      c_lo_ff;
   logic                      c_shot_ff;
   logic [NIB_W-1:0]          c_vol_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SAMPLE_W-1:0] res_ff;
   logic                      rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   logic            accept;
   op_type          op;
   logic            low_wr, high_wr, trig_hit;
   logic [2:0]      addr_voice;
   logic            voice_ok;
   logic            run_done;
   logic            out_load;

   logic [PHASE_BITS-1:0] ph_rd, ph_next, ph_wdata;
   logic                  ph_we;
   logic [VIW-1:0]        ph_waddr;
   logic                  b_active, b_fetch;
   logic [SW-1:0]         wsum, wsum1, wsum2;
   logic [IDXW-1:0]       byte_idx;
   logic [RAW-1:0]        rom_raddr;
   logic [DATA_W-1:0]     rom_rdata;
   logic [NIB_W-1:0]      nib;
   logic signed [9:0]     contrib;

   scale_req_type sreq;
   scale_rsp_type srsp;

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign op           = op_type'(req_if.operation);
   assign addr_voice   = req_if.address[5:3];
   assign voice_ok     = ({1'b0, addr_voice} < 4'(MIX_VOICES));
   assign low_wr  = accept && (op == OP_REG_WRITE) && (req_if.address[14:6] == '0);
   assign high_wr = accept && (op == OP_REG_WRITE) && (req_if.address[14:13] == 2'b01);
   assign trig_hit = high_wr && voice_ok && shot_w[addr_voice[VIW-1:0]];

   // decode of every voice from the current register bank
   always_comb begin
      for (int v = 0; v < MIX_VOICES; v++) begin
         freq_w[v] = {low_regs_ff[8*v+2], low_regs_ff[8*v+1], low_regs_ff[8*v]};
         vol_w[v]  = low_regs_ff[8*v+7];
         shot_w[v] = (low_regs_ff[8*v+5] != '0);
         base_w[v] = shot_w[v] ? {low_regs_ff[8*v+5], hbl_ff[v], 7'b0}
                               : {7'b0, low_regs_ff[8*v+3], 4'b0};
         // one-shot select as it stands after the current low bank write
         new_shot_w[v] = (req_if.address[5:0] == 6'(8*v+5))
                       ? (req_if.data[NIB_W-1:0] != '0) : shot_w[v];
      end
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         enable_ff <= 1'b1;
         for (int i = 0; i < LOW_REGS; i++) begin
            low_regs_ff[i] <= '0;
         end
         for (int v = 0; v < MIX_VOICES; v++) begin
            hb5_ff[v] <= '0;
            hbl_ff[v] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GAIN:   gain_ff   <= csr_wdata[GAIN_W-1:0];
               CSR_ENABLE: enable_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (low_wr) begin
            low_regs_ff[req_if.address[5:0]] <= req_if.data[NIB_W-1:0];
            for (int v = 0; v < MIX_VOICES; v++) begin
               hbl_ff[v] <= hb5_ff[v];
            end
         end
         if (high_wr && (req_if.address[12:6] == '0) && (req_if.address[2:0] == 3'd5)
             && voice_ok) begin
            hb5_ff[addr_voice[VIW-1:0]] <= req_if.data[NIB_W-1:0];
         end
      end
   end

   // play flags: set by trigger, cleared when a voice turns looping or hits the end byte
   always_comb begin
      playing_in = playing_ff;
      if (low_wr) begin
         playing_in = playing_ff & new_shot_w;
      end
      if (trig_hit) begin
         playing_in[addr_voice[VIW-1:0]] = 1'b1;
      end
      if (c_valid_ff && c_shot_ff && (rom_rdata == END_BYTE)) begin
         playing_in[c_voice_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= '0;
      end else begin
         playing_ff <= playing_in;
      end
   end

   // stage b: phase advance and wave address
   always_comb begin
      b_active = b_valid_ff && (vol_w[b_voice_ff] != '0) && (freq_w[b_voice_ff] != '0);
      ph_next  = ph_rd + PHASE_BITS'({freq_w[b_voice_ff], 4'b0000});
      byte_idx = shot_w[b_voice_ff] ? ph_next[PHASE_BITS-1:16]
                                    : IDXW'(ph_next[19:16]);
      b_fetch  = b_active && (!shot_w[b_voice_ff] || playing_ff[b_voice_ff]);
      wsum     = SW'(base_w[b_voice_ff]) + SW'(byte_idx);
      wsum1    = (wsum >= SW'(2 * ROM_BYTES)) ? wsum - SW'(2 * ROM_BYTES) : wsum;
      wsum2    = (wsum1 >= SW'(ROM_BYTES)) ? wsum1 - SW'(ROM_BYTES) : wsum1;
      rom_raddr = wsum2[RAW-1:0];
      ph_we    = b_active || trig_hit;
      ph_waddr = b_active ? b_voice_ff : addr_voice[VIW-1:0];
      ph_wdata = b_active ? ph_next : '0;
   end

   // stage c: nibble times volume
   always_comb begin
      nib     = c_lo_ff ? rom_rdata[3:0] : rom_rdata[7:4];
      contrib = ($signed({1'b0, nib}) - 5'sd8) * $signed({1'b0, c_vol_ff});
   end

   assign run_done = (cnt_ff == CW'(MIX_VOICES)) && !b_valid_ff && !c_valid_ff;

   // finished sample moves to the output register when it is empty or drains now
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   wvm_phase_mem #(
      .DEPTH (MIX_VOICES),
      .WIDTH (PHASE_BITS),
      .AW    (VIW)
   ) u_phase (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ph_we),
      .wr_addr (ph_waddr),
      .wr_data (ph_wdata),
      .rd_addr (cnt_ff[VIW-1:0]),
      .rd_data (ph_rd)
   );

   wvm_wave_mem #(
      .DEPTH (ROM_BYTES),
      .AW    (RAW)
   ) u_wave (
      .clock   (clock),
      .wr_en   (accept && (op == OP_ROM_LOAD)),
      .wr_addr (RAW'(req_if.address)),
      .wr_data (req_if.data),
      .rd_addr (rom_raddr),
      .rd_data (rom_rdata)
   );

   assign sreq.start = (state_ff == ST_RUN) && run_done;
   assign sreq.sum   = sum_ff;
   assign sreq.gain  = gain_ff;

   wvm_mix_scaler #(
      .MIX_VOICES (MIX_VOICES)
   ) u_scaler (
      .clock (clock),
      .reset (reset),
      .req   (sreq),
      .rsp   (srsp)
   );

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= out_load || (rsp_valid_ff && !rsp_if.ready);
         b_valid_ff <= (state_ff == ST_RUN) && (cnt_ff < CW'(MIX_VOICES));
         c_valid_ff <= b_fetch;
         c_voice_ff <= b_voice_ff;
         c_lo_ff    <= ph_next[15];
         c_shot_ff  <= shot_w[b_voice_ff];
         c_vol_ff   <= vol_w[b_voice_ff];
         if (c_valid_ff && !(c_shot_ff && (rom_rdata == END_BYTE))) begin
            sum_ff <= sum_ff + SUM_W'(contrib);
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (op == OP_TICK)) begin
                  if (enable_ff) begin
                     state_ff <= ST_RUN;
                     cnt_ff   <= '0;
                     sum_ff   <= '0;
                  end else begin
                     res_ff   <= '0;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_RUN: begin
               if (cnt_ff < CW'(MIX_VOICES)) begin
                  b_voice_ff <= cnt_ff[VIW-1:0];
                  cnt_ff     <= cnt_ff + 1'b1;
               end
               if (run_done) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (srsp.done) begin
                  res_ff   <= srsp.sample;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_load) begin
                  rsp_sample_ff <= res_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = rsp_sample_ff;

   // voice pipeline only runs during a tick
   a_pipe_in_run: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff || c_valid_ff) |-> (state_ff == ST_RUN))
      else $error("voice pipeline active outside a tick");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MIX_VOICES))
      else $error("voice issue count past the voice count");

   a_scale_done: assert property (@(posedge clock) disable iff (reset)
      srsp.done |-> (state_ff == ST_SCALE))
      else $error("scaler finished outside the scale state");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (sum_ff <= SUM_W'(120 * MIX_VOICES)) && (sum_ff >= -SUM_W'(120 * MIX_VOICES)))
      else $error("mix sum outside the voice range");

   a_start_once: assert property (@(posedge clock) disable iff (reset)
      sreq.start |=> (state_ff == ST_SCALE) && !sreq.start)
      else $error("scaler started twice for one tick");

endmodule
